/* hw/rtl/rcpcb_pkg.sv */
`default_nettype none

package rcpcb_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CH_W    = 4;
  localparam int unsigned TICKS_W = 24;
  localparam int unsigned OVR_W   = 16;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned MASK_W  = 8;

  localparam logic [MASK_W-1:0] MASK_RESET = 8'h0F;

  // floor(x / 100) == (x * ceil(2^31 / 100)) >> 31 for every 24-bit x
  localparam int unsigned DIV_MULT_W = 25;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 25'd21474837;
  localparam int unsigned DIV_SHIFT = 31;
  localparam int unsigned PROD_W    = TICKS_W + DIV_MULT_W;
  localparam int unsigned QUOT_W    = PROD_W - DIV_SHIFT;

  typedef enum logic [CMD_W-1:0] {
    CMD_CAPTURE = 3'd0,
    CMD_READ    = 3'd1,
    CMD_SET     = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_POLL    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load_item;
    logic execute;
    logic finish_div;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_div;
  } dp_status_t;

  function automatic logic [TICKS_W-1:0] neutral_width(input logic [CH_W-1:0] ch);
    logic [TICKS_W-1:0] w;
    case (ch)
      4'd0, 4'd1, 4'd3: w = 24'd150000;
      4'd2:             w = 24'd90000;
      4'd6:             w = 24'd190000;
      default:          w = 24'd100000;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rc_pulse_channel_bank_unit.sv */
`default_nettype none

// channel  direction  handshake               payload
// in       sink       in_valid_i / in_stall_o   cmd, channel, falling_edge, capture_ticks,
//                                               override_value
// out      source     out_valid_o / out_stall_i read_value, flag
// cfg      sink       cfg_we_i                  cfg_wdata_i (update_mask)
//
// one transaction at a time: accept, execute, then the result is offered; a read
// of a stored width adds a divide step between execute and offer, which finishes
// the reciprocal multiply by 1/100
// reset restores neutral pulse widths, clears overrides and flags, mask 0x0F
// a stalled result holds and the input stays stalled until it is taken

module rc_pulse_channel_bank_unit #(
  parameter int unsigned CHAN_COUNT = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rcpcb_pkg::MASK_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rcpcb_pkg::CMD_W-1:0]         cmd_i,
  input  logic [rcpcb_pkg::CH_W-1:0]          channel_i,
  input  logic                                falling_edge_i,
  input  logic [rcpcb_pkg::TICKS_W-1:0]       capture_ticks_i,
  input  logic signed [rcpcb_pkg::OVR_W-1:0]  override_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rcpcb_pkg::VALUE_W-1:0]       read_value_o,
  output logic                                flag_o
);
  import rcpcb_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  rcpcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (dp_cmd)
  );

  rcpcb_datapath #(
    .CHAN_COUNT (CHAN_COUNT)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .status_o            (dp_status),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .item_cmd_i          (cmd_i),
    .item_channel_i      (channel_i),
    .item_falling_edge_i (falling_edge_i),
    .item_ticks_i        (capture_ticks_i),
    .item_override_i     (override_value_i),
    .read_value_o        (read_value_o),
    .flag_o              (flag_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/rcpcb_ctrl.sv */
`default_nettype none

module rcpcb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   out_stall_i,
  input  rcpcb_pkg::dp_status_t  status_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output rcpcb_pkg::dp_cmd_t     cmd_o
);
  import rcpcb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        // width reads go through the reciprocal multiply first
        state_d = status_i.needs_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd_o.finish_div = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_EXEC)
    else $error("accepted transaction did not start execution");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input taken while a result is pending");

  a_div_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC && status_i.needs_div |=> state_q == S_DIV)
    else $error("width read skipped the divide step");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rcpcb_datapath.sv */
`default_nettype none

module rcpcb_datapath #(
  parameter int unsigned CHAN_COUNT = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  rcpcb_pkg::dp_cmd_t                     cmd_i,
  output rcpcb_pkg::dp_status_t                  status_o,
  input  logic                                   cfg_we_i,
  input  logic [rcpcb_pkg::MASK_W-1:0]           cfg_wdata_i,
  input  logic [rcpcb_pkg::CMD_W-1:0]            item_cmd_i,
  input  logic [rcpcb_pkg::CH_W-1:0]             item_channel_i,
  input  logic                                   item_falling_edge_i,
  input  logic [rcpcb_pkg::TICKS_W-1:0]          item_ticks_i,
  input  logic signed [rcpcb_pkg::OVR_W-1:0]     item_override_i,
  output logic [rcpcb_pkg::VALUE_W-1:0]          read_value_o,
  output logic                                   flag_o
);
  import rcpcb_pkg::*;

  localparam int unsigned IDX_W = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
  localparam logic [CH_W:0] CH_LIMIT = (CH_W+1)'(CHAN_COUNT);
  localparam int unsigned EXT_W = CHAN_COUNT + MASK_W;
  localparam int unsigned STORE_W = OVR_W - 1;

  // latched transaction
  cmd_e                     cmd_q;
  logic [CH_W-1:0]          chan_q;
  logic                     fall_q;
  logic [TICKS_W-1:0]       ticks_q;
  logic signed [OVR_W-1:0]  ovr_val_q;

  // channel state
  logic [TICKS_W-1:0]       pw_q  [CHAN_COUNT];
  logic [STORE_W-1:0]       ovr_q [CHAN_COUNT];
  logic [CHAN_COUNT-1:0]    seen_q;
  logic                     updated_q;
  logic                     ov_valid_q;
  logic [MASK_W-1:0]        mask_q;

  logic [PROD_W-1:0]        prod_q;
  logic [VALUE_W-1:0]       value_q;
  logic                     flag_q;

  logic [IDX_W-1:0]         idx;
  logic                     in_range;
  logic [STORE_W-1:0]       sel_ovr;
  logic [TICKS_W-1:0]       sel_pw;
  logic                     needs_div;
  logic                     capture_hit;
  logic                     ovr_write;
  logic                     ovr_nonzero;
  logic [CHAN_COUNT-1:0]    seen_set;
  logic [EXT_W-1:0]         seen_ext;
  logic                     covered;
  logic [QUOT_W-1:0]        quot;
  logic [VALUE_W-1:0]       quot_sat;
  logic [VALUE_W-1:0]       res_value;
  logic                     res_flag;

  assign idx         = chan_q[IDX_W-1:0];
  assign in_range    = {1'b0, chan_q} < CH_LIMIT;
  assign sel_ovr     = ovr_q[idx];
  assign sel_pw      = pw_q[idx];
  assign needs_div   = (cmd_q == CMD_READ) && in_range && (sel_ovr == '0);
  assign status_o.needs_div = needs_div;

  assign capture_hit = cmd_i.execute && (cmd_q == CMD_CAPTURE) && fall_q && in_range;
  assign ovr_write   = cmd_i.execute && (cmd_q == CMD_SET) && !ovr_val_q[OVR_W-1] && in_range;
  assign ovr_nonzero = ovr_val_q != '0;

  // mask bits past the last channel stay zero here and so never cover
  assign seen_set = seen_q | (CHAN_COUNT'(1) << idx);
  assign seen_ext = EXT_W'(seen_set);
  assign covered  = (seen_ext[MASK_W-1:0] & mask_q) == mask_q;

  assign quot     = prod_q[PROD_W-1:DIV_SHIFT];
  assign quot_sat = (|quot[QUOT_W-1:VALUE_W]) ? '1 : quot[VALUE_W-1:0];

  always_comb begin
    res_value = '0;
    res_flag  = 1'b0;
    case (cmd_q)
      CMD_READ: begin
        if (in_range && sel_ovr != '0) begin
          res_value = VALUE_W'(sel_ovr);
        end
      end
      CMD_SET: begin
        res_flag = !ovr_val_q[OVR_W-1] && in_range && ovr_nonzero;
      end
      CMD_POLL: begin
        res_flag = ov_valid_q | updated_q;
      end
      default: begin
        res_value = '0;
        res_flag  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q     <= cmd_e'(item_cmd_i);
      chan_q    <= item_channel_i;
      fall_q    <= item_falling_edge_i;
      ticks_q   <= item_ticks_i;
      ovr_val_q <= item_override_i;
    end
    if (cmd_i.execute) begin
      prod_q <= PROD_W'(sel_pw) * PROD_W'(DIV_MULT);
    end
    if (cmd_i.execute) begin
      value_q <= res_value;
      flag_q  <= res_flag;
    end else if (cmd_i.finish_div) begin
      value_q <= quot_sat;
      flag_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHAN_COUNT; i++) begin
        pw_q[i] <= neutral_width(CH_W'(i));
      end
    end else if (capture_hit) begin
      pw_q[idx] <= ticks_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHAN_COUNT; i++) begin
        ovr_q[i] <= '0;
      end
    end else if (cmd_i.execute && cmd_q == CMD_CLEAR) begin
      for (int i = 0; i < CHAN_COUNT; i++) begin
        ovr_q[i] <= '0;
      end
    end else if (ovr_write) begin
      ovr_q[idx] <= ovr_val_q[STORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      updated_q  <= 1'b0;
      ov_valid_q <= 1'b0;
      mask_q     <= MASK_RESET;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (capture_hit) begin
        seen_q <= covered ? '0 : seen_set;
      end
      if (capture_hit && covered) begin
        updated_q <= 1'b1;
      end else if (cmd_i.execute && needs_div) begin
        updated_q <= 1'b0;
      end
      if (ovr_write && ovr_nonzero) begin
        ov_valid_q <= 1'b1;
      end else if (cmd_i.execute && cmd_q == CMD_POLL) begin
        // poll reports the override flag OR updated, then consumes only the override flag
        ov_valid_q <= 1'b0;
      end
    end
  end

  assign read_value_o = value_q;
  assign flag_o       = flag_q;

`ifndef NO_ASSERTIONS
  logic any_ovr;
  always_comb begin
    any_ovr = 1'b0;
    for (int i = 0; i < CHAN_COUNT; i++) begin
      any_ovr = any_ovr | (ovr_q[i] != '0);
    end
  end

  a_poll_consumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && cmd_q == CMD_POLL |=> !ov_valid_q)
    else $error("poll left override flag set");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && cmd_q == CMD_CLEAR |=> !any_ovr)
    else $error("override clear left an entry");

  a_mask_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture_hit && covered |=> updated_q && seen_q == '0)
    else $error("completed mask did not raise updated");
`endif

endmodule

`default_nettype wire
